FILE: design/ohlc_pkg.sv
package ohlc_pkg;

    localparam int PRICE_W = 32;
    localparam int QTY_W   = 32;
    localparam int TS_W    = 48;
    localparam int ACC_W   = 48;
    localparam int SIZE_W  = 48;
    localparam int WIN_W   = 32;
    localparam int IVL_W   = 64;
    localparam int CFG_W   = 48;

    localparam logic [15:0]      MS_PER_MINUTE     = 16'd60000;
    localparam logic [WIN_W-1:0] HOLD_WINDOW_RESET = 32'd30000;

    typedef enum logic [2:0] {
        STAT_UPDATED = 3'd0,
        STAT_NEW_BAR = 3'd1,
        STAT_INVALID = 3'd2,
        STAT_HELD    = 3'd3,
        STAT_LATE    = 3'd4,
        STAT_IGNORED = 3'd5
    } status_t;

    localparam logic [1:0] KIND_TIME     = 2'd0;
    localparam logic [1:0] KIND_TICK     = 2'd1;
    localparam logic [1:0] KIND_VOLUME   = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    localparam logic OP_PRIMARY = 1'b0;
    localparam logic OP_AGG     = 1'b1;
    localparam logic SIDE_SELL  = 1'b1;

    localparam logic [1:0] CFG_BAR_KIND    = 2'd0;
    localparam logic [1:0] CFG_BAR_SIZE    = 2'd1;
    localparam logic [1:0] CFG_HOLD_ENABLE = 2'd2;
    localparam logic [1:0] CFG_HOLD_WINDOW = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_APPLY
    } state_t;

endpackage

FILE: design/ohlc_div.sv
module ohlc_div
    import ohlc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [TS_W-1:0]  dividend,
    input  logic [IVL_W-1:0] divisor,
    output logic             done,
    output logic [TS_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(TS_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(TS_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [TS_W-1:0]  dvd_reg;
    logic [TS_W-1:0]  rem_reg;

    logic [TS_W:0]    trial;
    logic             fits;

    // One restoring step per cycle: shift in the next dividend bit and subtract
    // the divisor when it fits.
    always_comb begin
        trial = {rem_reg, dvd_reg[TS_W-1]};
        fits  = {{(IVL_W-TS_W-1){1'b0}}, trial} >= divisor;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[TS_W-2:0], 1'b0};
            if (fits) begin
                rem_reg <= TS_W'({{(IVL_W-TS_W-1){1'b0}}, trial} - divisor);
            end else begin
                rem_reg <= trial[TS_W-1:0];
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: design/ohlc_bar_aggregator_top.sv
// Sequence: a time-bar print that reaches the bucket step goes through check, interval
// multiply, 48 divider steps and update after acceptance; every other print goes
// through check and update.
// Flow: one print at a time; the next print is accepted only once the update has run,
// and the update waits for m_ready to free the output register when it is full.
// Reset (aresetn, synchronous, active low) clears the bar, the registers to their
// defaults and the output channel; the block is ready on the first cycle after reset.
module ohlc_bar_aggregator_top
    import ohlc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_wr_en,
    input  logic [1:0]              cfg_index,
    input  logic [CFG_W-1:0]        cfg_wdata,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_operation,
    input  logic [PRICE_W-1:0]      s_price,
    input  logic [QTY_W-1:0]        s_quantity,
    input  logic                    s_side,
    input  logic [TS_W-1:0]         s_timestamp_ms,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [2:0]              m_status,
    output logic                    m_bar_valid,
    output logic [TS_W-1:0]         m_bar_start,
    output logic [PRICE_W-1:0]      m_bar_open,
    output logic [PRICE_W-1:0]      m_bar_high,
    output logic [PRICE_W-1:0]      m_bar_low,
    output logic [PRICE_W-1:0]      m_bar_close,
    output logic [ACC_W-1:0]        m_bar_volume,
    output logic [ACC_W-1:0]        m_agg_volume,
    output logic signed [ACC_W-1:0] m_net_delta
);

    localparam logic [ACC_W-1:0] ACC_MAX = '1;
    localparam logic signed [ACC_W+1:0] DELTA_MAX = {3'b000, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W+1:0] DELTA_MIN = {3'b111, {(ACC_W-1){1'b0}}};

    // Saturating unsigned add of two accumulator-wide values.
    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
    endfunction

    // Signed delta plus or minus an unsigned quantity, clamped to the 48-bit range.
    function automatic logic signed [ACC_W-1:0] delta_add(input logic signed [ACC_W-1:0] d,
                                                          input logic [QTY_W-1:0] q,
                                                          input logic sell);
        logic signed [ACC_W+1:0] de;
        logic signed [ACC_W+1:0] qe;
        logic signed [ACC_W+1:0] r;
        de = {{2{d[ACC_W-1]}}, d};
        qe = {{(ACC_W+2-QTY_W){1'b0}}, q};
        r  = sell ? de - qe : de + qe;
        if (r > DELTA_MAX) begin
            r = DELTA_MAX;
        end else if (r < DELTA_MIN) begin
            r = DELTA_MIN;
        end
        return r[ACC_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Config registers. Writes must arrive only while the block is idle; unenforced.
    // ------------------------------------------------------------------
    logic [1:0]        bar_kind_reg;
    logic [SIZE_W-1:0] bar_size_reg;
    logic [WIN_W-1:0]  hold_window_reg;

    // Hold-for-history state. Writing hold_enable rearms it directly, so no
    // separate copy of the enable bit is kept.
    logic              awaiting_reg, awaiting_next;
    logic [TS_W-1:0]   wait_start_reg, wait_start_next;

    // Forming bar.
    logic                    have_bar_reg, have_bar_next;
    logic [TS_W-1:0]         cur_start_reg, cur_start_next;
    logic [PRICE_W-1:0]      cur_open_reg, cur_open_next;
    logic [PRICE_W-1:0]      cur_high_reg, cur_high_next;
    logic [PRICE_W-1:0]      cur_low_reg, cur_low_next;
    logic [PRICE_W-1:0]      cur_close_reg, cur_close_next;
    logic [ACC_W-1:0]        cur_volume_reg, cur_volume_next;
    logic [ACC_W-1:0]        cur_agg_reg, cur_agg_next;
    logic signed [ACC_W-1:0] cur_delta_reg, cur_delta_next;
    logic [ACC_W-1:0]        trade_count_reg, trade_count_next;

    // Sequencer and the captured transaction.
    state_t            state_reg, state_next;
    logic              in_op_reg;
    logic [PRICE_W-1:0] in_price_reg;
    logic [QTY_W-1:0]  in_qty_reg;
    logic              in_side_reg;
    logic [TS_W-1:0]   in_ts_reg;
    logic              early_reg, early_next;
    status_t           early_status_reg, early_status_next;
    logic [IVL_W-1:0]  interval_reg;

    // Output register that separates the work from the result channel.
    logic              m_valid_reg;
    status_t           m_status_reg;
    logic              m_bar_valid_reg;
    logic [TS_W-1:0]   m_bar_start_reg;
    logic [PRICE_W-1:0] m_bar_open_reg, m_bar_high_reg, m_bar_low_reg, m_bar_close_reg;
    logic [ACC_W-1:0]  m_bar_volume_reg, m_agg_volume_reg;
    logic signed [ACC_W-1:0] m_net_delta_reg;

    logic              in_fire;
    logic              apply_fire;
    logic              div_start;
    logic              div_done;
    logic [TS_W-1:0]   div_rem;
    logic [TS_W-1:0]   bucket;
    logic [SIZE_W-1:0] size_eff;
    status_t           status_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_fire = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Bucket start for time bars: the timestamp minus its remainder modulo the
    // interval. The divider walks the 48 timestamp bits, one per cycle, and is
    // the only long-latency unit in the block.
    // ------------------------------------------------------------------
    assign size_eff = (bar_size_reg == '0) ? SIZE_W'(1) : bar_size_reg;
    assign bucket   = in_ts_reg - div_rem;

    ohlc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (in_ts_reg),
        .divisor   (interval_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // ------------------------------------------------------------------
    // Sequencer. CHECK settles the invalid, hold and ignore cases and decides
    // whether a bucket is needed; APPLY folds the print into the bar and loads
    // the output register once it is free.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        logic [TS_W-1:0] ws;
        logic [TS_W-1:0] since;
        logic            invalid;
        logic            held;
        ws      = '0;
        since   = '0;
        invalid = 1'b0;
        held    = 1'b0;

        state_next        = state_reg;
        awaiting_next     = awaiting_reg;
        wait_start_next   = wait_start_reg;
        early_next        = early_reg;
        early_status_next = early_status_reg;
        div_start         = 1'b0;
        apply_fire        = 1'b0;

        if (cfg_wr_en && cfg_index == CFG_HOLD_ENABLE) begin
            awaiting_next   = cfg_wdata[0];
            wait_start_next = '0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                invalid = (in_price_reg == '0) || (in_qty_reg == '0) || (in_ts_reg == '0);
                if (!invalid && awaiting_reg) begin
                    ws              = (wait_start_reg == '0) ? in_ts_reg : wait_start_reg;
                    since           = in_ts_reg - ws;
                    held            = (in_ts_reg < ws) ||
                                      (since < {{(TS_W-WIN_W){1'b0}}, hold_window_reg});
                    wait_start_next = ws;
                    if (!held) begin
                        awaiting_next = 1'b0;
                    end
                end
                early_next        = 1'b1;
                early_status_next = STAT_UPDATED;
                state_next        = ST_APPLY;
                if (invalid) begin
                    early_status_next = STAT_INVALID;
                end else if (held) begin
                    early_status_next = STAT_HELD;
                end else if (bar_kind_reg == KIND_RESERVED) begin
                    early_status_next = STAT_IGNORED;
                end else if (in_op_reg == OP_PRIMARY && bar_kind_reg == KIND_VOLUME) begin
                    early_status_next = STAT_IGNORED;
                end else begin
                    early_next = 1'b0;
                    if (bar_kind_reg == KIND_TIME) begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (!m_valid_reg || m_ready) begin
                    apply_fire = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Bar update for a print that passed the early checks.
    // ------------------------------------------------------------------
    always_comb begin
        logic [TS_W-1:0]         start_v;
        logic                    same;
        logic                    late;
        logic [ACC_W-1:0]        agg_base;
        logic signed [ACC_W-1:0] delta_base;
        logic [ACC_W-1:0]        qty_w;
        start_v    = '0;
        same       = 1'b0;
        late       = 1'b0;
        agg_base   = cur_agg_reg;
        delta_base = cur_delta_reg;
        qty_w      = {{(ACC_W-QTY_W){1'b0}}, in_qty_reg};

        have_bar_next    = have_bar_reg;
        cur_start_next   = cur_start_reg;
        cur_open_next    = cur_open_reg;
        cur_high_next    = cur_high_reg;
        cur_low_next     = cur_low_reg;
        cur_close_next   = cur_close_reg;
        cur_volume_next  = cur_volume_reg;
        cur_agg_next     = cur_agg_reg;
        cur_delta_next   = cur_delta_reg;
        trade_count_next = trade_count_reg;
        status_next      = early_status_reg;

        if (!early_reg) begin
            if (in_op_reg == OP_PRIMARY) begin
                start_v = (bar_kind_reg == KIND_TIME) ? bucket : in_ts_reg;
                if (have_bar_reg) begin
                    if (bar_kind_reg == KIND_TIME) begin
                        late = start_v < cur_start_reg;
                        same = start_v == cur_start_reg;
                    end else begin
                        same = trade_count_reg < bar_size_reg;
                    end
                end
                if (late) begin
                    status_next = STAT_LATE;
                end else if (have_bar_reg && same) begin
                    if (in_price_reg > cur_high_reg) begin
                        cur_high_next = in_price_reg;
                    end
                    if (in_price_reg < cur_low_reg) begin
                        cur_low_next = in_price_reg;
                    end
                    cur_close_next  = in_price_reg;
                    cur_volume_next = sat_add(cur_volume_reg, qty_w);
                    if (bar_kind_reg == KIND_TICK) begin
                        trade_count_next = sat_add(trade_count_reg, ACC_W'(1));
                    end
                    status_next = STAT_UPDATED;
                end else begin
                    have_bar_next    = 1'b1;
                    cur_start_next   = start_v;
                    cur_open_next    = in_price_reg;
                    cur_high_next    = in_price_reg;
                    cur_low_next     = in_price_reg;
                    cur_close_next   = in_price_reg;
                    cur_volume_next  = qty_w;
                    cur_agg_next     = '0;
                    cur_delta_next   = '0;
                    trade_count_next = ACC_W'(1);
                    status_next      = STAT_NEW_BAR;
                end
            end else if (bar_kind_reg == KIND_VOLUME) begin
                // In volume mode the aggregated print owns the bar boundary.
                if (!have_bar_reg || cur_agg_reg >= bar_size_reg) begin
                    have_bar_next   = 1'b1;
                    cur_start_next  = in_ts_reg;
                    cur_open_next   = in_price_reg;
                    cur_high_next   = in_price_reg;
                    cur_low_next    = in_price_reg;
                    cur_volume_next = '0;
                    agg_base        = '0;
                    delta_base      = '0;
                    status_next     = STAT_NEW_BAR;
                end else begin
                    if (in_price_reg > cur_high_reg) begin
                        cur_high_next = in_price_reg;
                    end
                    if (in_price_reg < cur_low_reg) begin
                        cur_low_next = in_price_reg;
                    end
                    status_next = STAT_UPDATED;
                end
                cur_close_next = in_price_reg;
                cur_agg_next   = sat_add(agg_base, qty_w);
                cur_delta_next = delta_add(delta_base, in_qty_reg, in_side_reg == SIDE_SELL);
            end else if (!have_bar_reg) begin
                status_next = STAT_IGNORED;
            end else if (bar_kind_reg == KIND_TIME && bucket < cur_start_reg) begin
                status_next = STAT_LATE;
            end else begin
                // A print in a later bucket still adds to the current time bar.
                cur_agg_next   = sat_add(cur_agg_reg, qty_w);
                cur_delta_next = delta_add(cur_delta_reg, in_qty_reg, in_side_reg == SIDE_SELL);
                status_next    = STAT_UPDATED;
            end
        end
    end

    // ------------------------------------------------------------------
    // Control and bar state.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bar_kind_reg     <= KIND_TIME;
            bar_size_reg     <= SIZE_W'(1);
            hold_window_reg  <= HOLD_WINDOW_RESET;
            awaiting_reg     <= 1'b0;
            wait_start_reg   <= '0;
            early_reg        <= 1'b0;
            early_status_reg <= STAT_UPDATED;
            have_bar_reg     <= 1'b0;
            cur_start_reg    <= '0;
            cur_open_reg     <= '0;
            cur_high_reg     <= '0;
            cur_low_reg      <= '0;
            cur_close_reg    <= '0;
            cur_volume_reg   <= '0;
            cur_agg_reg      <= '0;
            cur_delta_reg    <= '0;
            trade_count_reg  <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_BAR_KIND:    bar_kind_reg    <= cfg_wdata[1:0];
                    CFG_BAR_SIZE:    bar_size_reg    <= cfg_wdata[SIZE_W-1:0];
                    CFG_HOLD_WINDOW: hold_window_reg <= cfg_wdata[WIN_W-1:0];
                    default: begin
                    end
                endcase
            end
            awaiting_reg     <= awaiting_next;
            wait_start_reg   <= wait_start_next;
            early_reg        <= early_next;
            early_status_reg <= early_status_next;
            if (apply_fire) begin
                have_bar_reg    <= have_bar_next;
                cur_start_reg   <= cur_start_next;
                cur_open_reg    <= cur_open_next;
                cur_high_reg    <= cur_high_next;
                cur_low_reg     <= cur_low_next;
                cur_close_reg   <= cur_close_next;
                cur_volume_reg  <= cur_volume_next;
                cur_agg_reg     <= cur_agg_next;
                cur_delta_reg   <= cur_delta_next;
                trade_count_reg <= trade_count_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: the captured transaction, the interval and the result.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_op_reg    <= s_operation;
            in_price_reg <= s_price;
            in_qty_reg   <= s_quantity;
            in_side_reg  <= s_side;
            in_ts_reg    <= s_timestamp_ms;
        end
        if (state_reg == ST_MUL) begin
            // The product needs the full interval width for the largest bar sizes.
            interval_reg <= IVL_W'(size_eff) * IVL_W'(MS_PER_MINUTE);
        end
        if (apply_fire) begin
            m_status_reg     <= status_next;
            m_bar_valid_reg  <= have_bar_next;
            m_bar_start_reg  <= cur_start_next;
            m_bar_open_reg   <= cur_open_next;
            m_bar_high_reg   <= cur_high_next;
            m_bar_low_reg    <= cur_low_next;
            m_bar_close_reg  <= cur_close_next;
            m_bar_volume_reg <= cur_volume_next;
            m_agg_volume_reg <= cur_agg_next;
            m_net_delta_reg  <= cur_delta_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_bar_valid  = m_bar_valid_reg;
    assign m_bar_start  = m_bar_start_reg;
    assign m_bar_open   = m_bar_open_reg;
    assign m_bar_high   = m_bar_high_reg;
    assign m_bar_low    = m_bar_low_reg;
    assign m_bar_close  = m_bar_close_reg;
    assign m_bar_volume = m_bar_volume_reg;
    assign m_agg_volume = m_agg_volume_reg;
    assign m_net_delta  = m_net_delta_reg;

`ifndef NO_ASSERTIONS
    // A result appears only out of the update step.
    a_result_from_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_APPLY))
        else $error("result transaction raised outside the update step");

    // The divider finishes only while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide step");

    // Once a bar exists it never goes away.
    a_bar_persists: assert property (@(posedge aclk) disable iff (!aresetn)
        have_bar_reg |=> have_bar_reg)
        else $error("forming bar lost");

    // The bar low never exceeds the bar high.
    a_low_le_high: assert property (@(posedge aclk) disable iff (!aresetn)
        have_bar_reg |-> cur_low_reg <= cur_high_reg)
        else $error("bar low above bar high");
`endif

endmodule

FILE: tb/sv/ohlc_bar_aggregator_top_test.sv
// Self-checking bench for the OHLC bar aggregator.
// A queue of pending trades feeds a driver that works on the falling clock edge.
// On each rising edge, every accepted trade is folded into a local copy of the
// forming bar. The snapshot that this produces is queued and compared, field by
// field, with the next bar the block returns.
module ohlc_bar_aggregator_top_test;
    import ohlc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 60;
    localparam logic [TS_W-1:0] ALL48 = 48'hFFFF_FFFF_FFFF;
    localparam logic SIDE_BUY = ~SIDE_SELL;
    localparam logic signed [63:0] DELTA_HI = 64'sd140737488355327;
    localparam logic signed [63:0] DELTA_LO = -64'sd140737488355328;

    typedef struct {
        logic               op;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic               side;
        logic [TS_W-1:0]    ts;
    } trade_t;

    typedef struct {
        status_t            status;
        logic               bar_valid;
        logic [TS_W-1:0]    start;
        logic [PRICE_W-1:0] open_px;
        logic [PRICE_W-1:0] high_px;
        logic [PRICE_W-1:0] low_px;
        logic [PRICE_W-1:0] close_px;
        logic [ACC_W-1:0]   volume;
        logic [ACC_W-1:0]   agg_volume;
        logic [ACC_W-1:0]   delta;
    } bar_snapshot_t;

    logic                    aclk           = 1'b0;
    logic                    aresetn        = 1'b0;
    logic                    cfg_wr_en      = 1'b0;
    logic [1:0]              cfg_index      = CFG_BAR_KIND;
    logic [CFG_W-1:0]        cfg_wdata      = '0;
    logic                    s_valid        = 1'b0;
    logic                    s_ready;
    logic                    s_operation    = OP_PRIMARY;
    logic [PRICE_W-1:0]      s_price        = '0;
    logic [QTY_W-1:0]        s_quantity     = '0;
    logic                    s_side         = SIDE_BUY;
    logic [TS_W-1:0]         s_timestamp_ms = '0;
    logic                    m_valid;
    logic                    m_ready        = 1'b0;
    logic [2:0]              m_status;
    logic                    m_bar_valid;
    logic [TS_W-1:0]         m_bar_start;
    logic [PRICE_W-1:0]      m_bar_open;
    logic [PRICE_W-1:0]      m_bar_high;
    logic [PRICE_W-1:0]      m_bar_low;
    logic [PRICE_W-1:0]      m_bar_close;
    logic [ACC_W-1:0]        m_bar_volume;
    logic [ACC_W-1:0]        m_agg_volume;
    logic signed [ACC_W-1:0] m_net_delta;

    ohlc_bar_aggregator_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_price        (s_price),
        .s_quantity     (s_quantity),
        .s_side         (s_side),
        .s_timestamp_ms (s_timestamp_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_bar_valid    (m_bar_valid),
        .m_bar_start    (m_bar_start),
        .m_bar_open     (m_bar_open),
        .m_bar_high     (m_bar_high),
        .m_bar_low      (m_bar_low),
        .m_bar_close    (m_bar_close),
        .m_bar_volume   (m_bar_volume),
        .m_agg_volume   (m_agg_volume),
        .m_net_delta    (m_net_delta)
    );

    always #10 aclk = ~aclk;

    // Bench bookkeeping. The idle percentages are changed between phases only.
    trade_t        pending_trades[$];
    bar_snapshot_t expected_bars[$];
    logic          s_fire       = 1'b0;
    int            send_idle_pct = 16;
    int            recv_idle_pct = 71;
    int            mismatches   = 0;
    int            results_seen = 0;
    int            idle_cycles  = 0;
    int            price_mid    = 100000;
    logic [TS_W-1:0] feed_ms    = 48'd10_000_000;

    // Local copy of the registers, at their reset values.
    logic [1:0]       mode_kind   = KIND_TIME;
    logic [SIZE_W-1:0] mode_size  = 48'd1;
    logic [WIN_W-1:0] hold_window = HOLD_WINDOW_RESET;

    // Local copy of the forming bar and of the hold state.
    logic               awaiting_history = 1'b0;
    logic [TS_W-1:0]    hold_since       = '0;
    logic               forming_valid    = 1'b0;
    logic [TS_W-1:0]    forming_start    = '0;
    logic [PRICE_W-1:0] forming_open     = '0;
    logic [PRICE_W-1:0] forming_high     = '0;
    logic [PRICE_W-1:0] forming_low      = '0;
    logic [PRICE_W-1:0] forming_close    = '0;
    logic [ACC_W-1:0]   forming_volume   = '0;
    logic [ACC_W-1:0]   forming_agg      = '0;
    logic signed [ACC_W-1:0] forming_delta = '0;
    logic [ACC_W-1:0]   tick_count       = '0;

    function automatic logic [ACC_W-1:0] sat_add48(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
        logic [ACC_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[ACC_W] ? ALL48 : sum[ACC_W-1:0];
    endfunction

    // A bar size of zero behaves as a one-minute bucket.
    function automatic logic [TS_W-1:0] bucket_start(logic [TS_W-1:0] ts);
        logic [IVL_W-1:0] span;
        span = ((mode_size == '0) ? 64'd1 : {16'd0, mode_size}) * MS_PER_MINUTE;
        return TS_W'(({16'd0, ts} / span) * span);
    endfunction

    function automatic void open_forming(logic [TS_W-1:0] start, logic [PRICE_W-1:0] price,
                                         logic [ACC_W-1:0] vol);
        forming_valid  = 1'b1;
        forming_start  = start;
        forming_open   = price;
        forming_high   = price;
        forming_low    = price;
        forming_close  = price;
        forming_volume = vol;
        forming_agg    = '0;
        forming_delta  = '0;
    endfunction

    function automatic void extend_prices(logic [PRICE_W-1:0] price);
        if (price > forming_high) forming_high = price;
        if (price < forming_low) forming_low = price;
        forming_close = price;
    endfunction

    // Folds one accepted trade into the local bar and returns the bar the block
    // should answer with.
    function automatic bar_snapshot_t fold_trade(logic op, logic [PRICE_W-1:0] price,
                                                 logic [QTY_W-1:0] qty, logic side,
                                                 logic [TS_W-1:0] ts);
        bar_snapshot_t   r;
        status_t         st;
        logic [TS_W-1:0] start;
        logic            held_now;
        logic            same;
        logic            late;
        logic            skip;
        logic signed [63:0] d;
        logic signed [63:0] q;
        st = STAT_UPDATED;
        held_now = 1'b0;
        if (price == '0 || qty == '0 || ts == '0) begin
            st = STAT_INVALID;
        end else begin
            // The hold is tested before the bar mode is even looked at.
            if (awaiting_history) begin
                if (hold_since == '0) hold_since = ts;
                if (ts < hold_since || (ts - hold_since) < {16'd0, hold_window}) begin
                    held_now = 1'b1;
                end else begin
                    awaiting_history = 1'b0;
                end
            end
            if (held_now) begin
                st = STAT_HELD;
            end else if (mode_kind == KIND_RESERVED) begin
                st = STAT_IGNORED;
            end else if (op == OP_PRIMARY) begin
                if (mode_kind == KIND_VOLUME) begin
                    st = STAT_IGNORED;
                end else begin
                    start = (mode_kind == KIND_TIME) ? bucket_start(ts) : ts;
                    same = 1'b0;
                    late = 1'b0;
                    if (forming_valid) begin
                        if (mode_kind == KIND_TIME) begin
                            late = start < forming_start;
                            same = start == forming_start;
                        end else begin
                            same = tick_count < mode_size;
                        end
                    end
                    if (late) begin
                        st = STAT_LATE;
                    end else if (same) begin
                        extend_prices(price);
                        forming_volume = sat_add48(forming_volume, ACC_W'(qty));
                        if (mode_kind == KIND_TICK) tick_count = sat_add48(tick_count, 48'd1);
                        st = STAT_UPDATED;
                    end else begin
                        open_forming(start, price, ACC_W'(qty));
                        tick_count = 48'd1;
                        st = STAT_NEW_BAR;
                    end
                end
            end else begin
                skip = 1'b0;
                if (mode_kind == KIND_VOLUME) begin
                    // In volume mode the aggregated print owns the bar boundary.
                    if (!forming_valid || forming_agg >= mode_size) begin
                        open_forming(ts, price, '0);
                        st = STAT_NEW_BAR;
                    end
                    extend_prices(price);
                end else if (!forming_valid) begin
                    st = STAT_IGNORED;
                    skip = 1'b1;
                end else if (mode_kind == KIND_TIME && bucket_start(ts) < forming_start) begin
                    st = STAT_LATE;
                    skip = 1'b1;
                end
                if (!skip) begin
                    forming_agg = sat_add48(forming_agg, ACC_W'(qty));
                    d = forming_delta;
                    q = {32'd0, qty};
                    d = (side == SIDE_SELL) ? d - q : d + q;
                    if (d > DELTA_HI) d = DELTA_HI;
                    if (d < DELTA_LO) d = DELTA_LO;
                    forming_delta = d[ACC_W-1:0];
                end
            end
        end
        r.status     = st;
        r.bar_valid  = forming_valid;
        r.start      = forming_start;
        r.open_px    = forming_open;
        r.high_px    = forming_high;
        r.low_px     = forming_low;
        r.close_px   = forming_close;
        r.volume     = forming_volume;
        r.agg_volume = forming_agg;
        r.delta      = forming_delta;
        return r;
    endfunction

    // Every mismatch is printed on one line and counted.
    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("bar %0d field %s is %0h, expected %0h",
                                      results_seen, name, got, want));
        end
    endtask

    // Monitor and scoreboard. Everything here is sampled at the rising edge, while
    // the inputs that the driver changed at the falling edge are stable.
    always @(posedge aclk) begin
        bar_snapshot_t want;
        s_fire <= s_valid && s_ready;
        if (s_valid && s_ready) begin
            expected_bars.insert(expected_bars.size(),
                                 fold_trade(s_operation, s_price, s_quantity, s_side,
                                            s_timestamp_ms));
        end
        if (m_valid && m_ready) begin
            if (expected_bars.size() == 0) begin
                report_mismatch($sformatf("bar %0d arrived with no trade outstanding",
                                          results_seen));
            end else begin
                want = expected_bars.pop_front();
                check_field("status", 64'(m_status), 64'(want.status));
                check_field("bar_valid", 64'(m_bar_valid), 64'(want.bar_valid));
                check_field("bar_start", 64'(m_bar_start), 64'(want.start));
                check_field("bar_open", 64'(m_bar_open), 64'(want.open_px));
                check_field("bar_high", 64'(m_bar_high), 64'(want.high_px));
                check_field("bar_low", 64'(m_bar_low), 64'(want.low_px));
                check_field("bar_close", 64'(m_bar_close), 64'(want.close_px));
                check_field("bar_volume", 64'(m_bar_volume), 64'(want.volume));
                check_field("agg_volume", 64'(m_agg_volume), 64'(want.agg_volume));
                check_field("net_delta", 64'($unsigned(m_net_delta)), 64'(want.delta));
            end
            results_seen++;
        end
    end

    // Driver. A new transaction is offered only when the previous one has been
    // taken or none was offered. The receiver's ready is rerolled every cycle.
    always @(negedge aclk) begin
        trade_t t;
        if (!s_valid || s_fire) begin
            if (pending_trades.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                t = pending_trades.pop_front();
                s_valid        <= 1'b1;
                s_operation    <= t.op;
                s_price        <= t.price;
                s_quantity     <= t.qty;
                s_side         <= t.side;
                s_timestamp_ms <= t.ts;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: the run is abandoned when neither channel moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_trade(input logic op, input logic [PRICE_W-1:0] price,
                               input logic [QTY_W-1:0] qty, input logic side,
                               input logic [TS_W-1:0] ts);
        pending_trades.insert(pending_trades.size(), trade_t'{op, price, qty, side, ts});
    endtask

    // Waits until every queued trade has been accepted and answered. The check is
    // made at the rising edge, where the queues and the valid are not in motion.
    task automatic drain();
        while (pending_trades.size() != 0 || s_valid || expected_bars.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (index)
            CFG_BAR_KIND:    mode_kind = value[1:0];
            CFG_BAR_SIZE:    mode_size = value[SIZE_W-1:0];
            CFG_HOLD_ENABLE: begin
                // Writing the enable rearms the hold and forgets its start time.
                awaiting_history = value[0];
                hold_since = '0;
            end
            CFG_HOLD_WINDOW: hold_window = value[WIN_W-1:0];
            default: ;
        endcase
    endtask

    // Registers are only written once the block has gone quiet. The hold enable
    // goes last so that the hold starts from a clean state.
    task automatic set_mode(input logic [1:0] kind, input logic [SIZE_W-1:0] size,
                            input logic hold_en, input logic [WIN_W-1:0] window);
        drain();
        write_register(CFG_BAR_KIND, CFG_W'(kind));
        write_register(CFG_BAR_SIZE, CFG_W'(size));
        write_register(CFG_HOLD_WINDOW, CFG_W'(window));
        write_register(CFG_HOLD_ENABLE, CFG_W'(hold_en));
    endtask

    // Random trades, mostly a plausible feed: time moves forward, the price walks
    // around a midpoint, and quantities are modest. A minority are zero fields,
    // full-range values, or prints that arrive behind the feed.
    task automatic queue_random(input int count, input int step_max);
        trade_t      t;
        int unsigned pick;
        for (int i = 0; i < count; i++) begin
            t.op = (mode_kind == KIND_VOLUME) ? ($urandom_range(3) != 0)
                                              : 1'($urandom_range(1));
            price_mid += int'($urandom_range(200)) - 100;
            if (price_mid < 1000) price_mid = 1000;
            pick = $urandom_range(99);
            if (pick < 4) t.price = '0;
            else if (pick < 7) t.price = $urandom;
            else if (pick < 9) t.price = '1;
            else if (pick < 10) t.price = 32'd1;
            else t.price = price_mid + $urandom_range(50);
            pick = $urandom_range(99);
            if (pick < 5) t.qty = '0;
            else if (pick < 12) t.qty = $urandom;
            else t.qty = $urandom_range(1000, 1);
            t.side = 1'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 4) begin
                t.ts = '0;
            end else if (pick < 10) begin
                t.ts = feed_ms - $urandom_range(3 * step_max, 1);
            end else begin
                feed_ms = feed_ms + $urandom_range(step_max);
                t.ts = feed_ms;
            end
            pending_trades.insert(pending_trades.size(), t);
        end
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed trades on the reset registers: one-minute time bars, no hold.
        // An aggregated print before any bar exists is ignored.
        queue_trade(OP_AGG, 32'd500, 32'd10, SIDE_BUY, 48'd1000);
        queue_trade(OP_PRIMARY, 32'd100, 32'd10, SIDE_BUY, 48'd60500);
        // A zero price, quantity or time is rejected without touching the bar.
        queue_trade(OP_PRIMARY, 32'd0, 32'd10, SIDE_BUY, 48'd61000);
        queue_trade(OP_PRIMARY, 32'd100, 32'd0, SIDE_BUY, 48'd61000);
        queue_trade(OP_AGG, 32'd100, 32'd10, SIDE_SELL, 48'd0);
        queue_trade(OP_PRIMARY, '1, '1, SIDE_BUY, 48'd61000);
        queue_trade(OP_PRIMARY, 32'd1, 32'd1, SIDE_BUY, 48'd62000);
        queue_trade(OP_AGG, 32'd7, '1, SIDE_BUY, 48'd62500);
        // Prints from an earlier bucket are late, whichever kind they are.
        queue_trade(OP_AGG, 32'd7, 32'd5, SIDE_SELL, 48'd1000);
        queue_trade(OP_PRIMARY, 32'd9, 32'd5, SIDE_BUY, 48'd30000);
        // An aggregated print from a later bucket still lands in the current bar.
        queue_trade(OP_AGG, 32'd8, 32'd3, SIDE_SELL, 48'd200000);
        queue_trade(OP_PRIMARY, '1, 32'd2, SIDE_SELL, ALL48);
        queue_trade(OP_PRIMARY, 32'd5, 32'd2, SIDE_BUY, 48'd200000);

        // With a tick size of zero, every primary trade opens a new bar.
        set_mode(KIND_TICK, '0, 1'b0, HOLD_WINDOW_RESET);
        queue_trade(OP_PRIMARY, 32'd200, 32'd4, SIDE_BUY, 48'd300000);
        queue_trade(OP_PRIMARY, 32'd210, 32'd4, SIDE_BUY, 48'd300100);
        queue_trade(OP_AGG, 32'd190, 32'd6, SIDE_SELL, 48'd300200);

        // Volume bars ignore primary trades; with size zero each print cuts a bar.
        set_mode(KIND_VOLUME, '0, 1'b0, HOLD_WINDOW_RESET);
        queue_trade(OP_PRIMARY, 32'd220, 32'd4, SIDE_BUY, 48'd300300);
        queue_trade(OP_AGG, 32'd230, 32'd8, SIDE_BUY, 48'd300400);
        queue_trade(OP_AGG, 32'd225, 32'd9, SIDE_SELL, 48'd300500);

        // The reserved bar kind ignores every well-formed print.
        set_mode(KIND_RESERVED, 48'd5, 1'b0, HOLD_WINDOW_RESET);
        queue_trade(OP_AGG, 32'd240, 32'd3, SIDE_BUY, 48'd300600);

        // Hold: the first print starts the window, an earlier one is held too, and
        // the first print at the end of the window goes through.
        set_mode(KIND_TICK, 48'd2, 1'b1, 32'd100);
        queue_trade(OP_PRIMARY, 32'd250, 32'd3, SIDE_BUY, 48'd500000);
        queue_trade(OP_PRIMARY, 32'd251, 32'd3, SIDE_BUY, 48'd499000);
        queue_trade(OP_AGG, 32'd252, 32'd3, SIDE_SELL, 48'd500099);
        queue_trade(OP_PRIMARY, 32'd253, 32'd3, SIDE_BUY, 48'd500100);

        // Random phases, first with a slow receiver.
        set_mode(KIND_TIME, 48'd1, 1'b0, HOLD_WINDOW_RESET);
        queue_random(120, 15000);
        set_mode(KIND_TICK, 48'd5, 1'b0, HOLD_WINDOW_RESET);
        queue_random(100, 5000);
        set_mode(KIND_TIME, '0, 1'b0, HOLD_WINDOW_RESET);
        queue_random(80, 20000);
        set_mode(KIND_VOLUME, 48'd5000, 1'b0, HOLD_WINDOW_RESET);
        queue_random(100, 3000);

        // Then a slow sender.
        set_mode(KIND_TICK, 48'd1, 1'b0, HOLD_WINDOW_RESET);
        send_idle_pct = 71;
        recv_idle_pct = 16;
        queue_random(60, 2000);
        set_mode(KIND_TIME, 48'd15, 1'b1, 32'd150000);
        queue_random(120, 60000);
        set_mode(KIND_VOLUME, '0, 1'b0, 32'd150000);
        queue_random(60, 1000);
        set_mode(KIND_TICK, ALL48, 1'b0, HOLD_WINDOW_RESET);
        queue_random(80, 5000);

        // Then both sides at full speed.
        set_mode(KIND_TIME, ALL48, 1'b0, HOLD_WINDOW_RESET);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(30, 5000);
        set_mode(KIND_RESERVED, 48'd7, 1'b1, '0);
        queue_random(40, 3000);
        set_mode(KIND_TICK, 48'd3, 1'b1, '1);
        queue_random(40, 3000);
        set_mode(KIND_TIME, 48'd2, 1'b0, HOLD_WINDOW_RESET);
        queue_random(150, 30000);
        set_mode(KIND_VOLUME, 48'd20000, 1'b0, HOLD_WINDOW_RESET);
        queue_random(100, 2000);

        drain();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: ohlc_bar_aggregator_top.f
design/ohlc_pkg.sv
design/ohlc_div.sv
design/ohlc_bar_aggregator_top.sv
tb/sv/ohlc_bar_aggregator_top_test.sv
